@@ src/tfn_pkg.sv @@
// shared types and constants for the triangle face normal pipeline
package tfn_pkg;

    localparam int COORD_W = 16;
    localparam int EDGE_W  = 17;
    localparam int PROD_W  = 34;
    localparam int MAG_W   = 34;
    localparam int POS_W   = 6;
    localparam int NRM_W   = 31;
    localparam int NRM_POS = 30;
    localparam int SQ_W    = 62;
    localparam int SUM_W   = 64;
    localparam int ROOT_W  = 32;
    localparam int REM_W   = 36;
    localparam int FRAC_W  = 14;
    localparam int NUM_W   = 46;
    localparam int QUO_W   = 15;
    localparam int OUT_W   = 16;

    typedef struct packed {
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic signed [COORD_W-1:0] third_x;
        logic signed [COORD_W-1:0] third_y;
        logic signed [COORD_W-1:0] third_z;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic                    degenerate;
    } t_out;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
    } t_cross;

    typedef struct packed {
        logic [2:0][NRM_W-1:0] m;
        logic [2:0]            neg;
        logic                  degen;
    } t_side;

endpackage

@@ src/tfn_cross.sv @@
// edge vectors, partial products and cross product magnitudes
module tfn_cross (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  tfn_pkg::t_in     i_data,
    output logic             o_vld,
    output tfn_pkg::t_cross  o_data
);
    logic signed [tfn_pkg::EDGE_W-1:0] n_e1 [3];
    logic signed [tfn_pkg::EDGE_W-1:0] n_e2 [3];
    logic signed [tfn_pkg::EDGE_W-1:0] r_e1 [3];
    logic signed [tfn_pkg::EDGE_W-1:0] r_e2 [3];
    logic signed [tfn_pkg::PROD_W-1:0] r_pa [3];
    logic signed [tfn_pkg::PROD_W-1:0] r_pb [3];
    logic signed [tfn_pkg::PROD_W:0]   n_c  [3];
    logic        [tfn_pkg::PROD_W:0]   n_abs [3];
    tfn_pkg::t_cross                   r_out;
    logic [2:0]                        r_vld;

    always_comb begin
        n_e1[0] = {i_data.third_x[15], i_data.third_x} - {i_data.second_x[15], i_data.second_x};
        n_e1[1] = {i_data.third_y[15], i_data.third_y} - {i_data.second_y[15], i_data.second_y};
        n_e1[2] = {i_data.third_z[15], i_data.third_z} - {i_data.second_z[15], i_data.second_z};
        n_e2[0] = {i_data.first_x[15], i_data.first_x} - {i_data.third_x[15], i_data.third_x};
        n_e2[1] = {i_data.first_y[15], i_data.first_y} - {i_data.third_y[15], i_data.third_y};
        n_e2[2] = {i_data.first_z[15], i_data.first_z} - {i_data.third_z[15], i_data.third_z};
        for (int i = 0; i < 3; i++) begin
            n_c[i]   = {r_pa[i][tfn_pkg::PROD_W-1], r_pa[i]}
                     - {r_pb[i][tfn_pkg::PROD_W-1], r_pb[i]};
            n_abs[i] = n_c[i][tfn_pkg::PROD_W] ? (~n_c[i] + 1'b1) : n_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
        if (i_en) begin
            r_e1 <= n_e1;
            r_e2 <= n_e2;
            r_pa[0] <= r_e1[1] * r_e2[2];
            r_pb[0] <= r_e1[2] * r_e2[1];
            r_pa[1] <= r_e1[2] * r_e2[0];
            r_pb[1] <= r_e1[0] * r_e2[2];
            r_pa[2] <= r_e1[0] * r_e2[1];
            r_pb[2] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_out.mag[i] <= n_abs[i][tfn_pkg::MAG_W-1:0];
                r_out.neg[i] <= n_c[i][tfn_pkg::PROD_W];
            end
        end
    end

    assign o_vld  = r_vld[2];
    assign o_data = r_out;
endmodule

@@ src/tfn_norm.sv @@
// common normalising shift, squares and sum of squares
module tfn_norm (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  tfn_pkg::t_cross  i_data,
    output logic             o_vld,
    output logic [tfn_pkg::SUM_W-1:0] o_sum,
    output tfn_pkg::t_side   o_side
);
    logic [tfn_pkg::MAG_W-1:0] n_mx;
    logic [tfn_pkg::POS_W-1:0] n_pos;
    logic [tfn_pkg::POS_W-1:0] r_pos;
    tfn_pkg::t_cross           r_a;
    logic                      r_degen_a;
    logic [63:0]               n_shf [3];
    tfn_pkg::t_side            r_b;
    tfn_pkg::t_side            r_c;
    tfn_pkg::t_side            r_d;
    logic [tfn_pkg::SQ_W-1:0]  r_sq [3];
    logic [tfn_pkg::SUM_W-1:0] r_sum;
    logic [3:0]                r_vld;

    always_comb begin
        n_mx = i_data.mag[0];
        if (i_data.mag[1] > n_mx) n_mx = i_data.mag[1];
        if (i_data.mag[2] > n_mx) n_mx = i_data.mag[2];
        n_pos = '0;
        for (int i = 0; i < tfn_pkg::MAG_W; i++) begin
            if (n_mx[i]) n_pos = tfn_pkg::POS_W'(i);
        end
        for (int i = 0; i < 3; i++) begin
            n_shf[i] = ({30'd0, r_a.mag[i]} << tfn_pkg::NRM_POS) >> r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_vld};
        end
        if (i_en) begin
            r_a       <= i_data;
            r_pos     <= n_pos;
            r_degen_a <= (n_mx == '0);
            for (int i = 0; i < 3; i++) begin
                r_b.m[i] <= n_shf[i][tfn_pkg::NRM_W-1:0];
                r_sq[i]  <= r_b.m[i] * r_b.m[i];
            end
            r_b.neg   <= r_a.neg;
            r_b.degen <= r_degen_a;
            r_c       <= r_b;
            r_d       <= r_c;
            r_sum     <= {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
        end
    end

    assign o_vld  = r_vld[3];
    assign o_sum  = r_sum;
    assign o_side = r_d;
endmodule

@@ src/tfn_sqrt.sv @@
// integer square root, one root bit per stage
module tfn_sqrt (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [tfn_pkg::SUM_W-1:0] i_sum,
    input  tfn_pkg::t_side   i_side,
    output logic             o_vld,
    output logic [tfn_pkg::ROOT_W-1:0] o_root,
    output tfn_pkg::t_side   o_side
);
    localparam int STAGES = tfn_pkg::ROOT_W;

    logic [tfn_pkg::REM_W-1:0]  r_rem  [STAGES];
    logic [tfn_pkg::ROOT_W-1:0] r_root [STAGES];
    logic [tfn_pkg::SUM_W-1:0]  r_s    [STAGES];
    tfn_pkg::t_side             r_side [STAGES];
    logic [STAGES-1:0]          r_vld;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [tfn_pkg::REM_W-1:0]  p_rem;
        logic [tfn_pkg::ROOT_W-1:0] p_root;
        logic [tfn_pkg::SUM_W-1:0]  p_s;
        tfn_pkg::t_side             p_side;
        logic                       p_vld;
        logic [tfn_pkg::REM_W-1:0]  n_sh;
        logic [tfn_pkg::REM_W-1:0]  n_try;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_s    = i_sum;
            assign p_side = i_side;
            assign p_vld  = i_vld;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
            assign p_s    = r_s[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        // bring down the next two bits of the radicand
        assign n_sh  = {p_rem[tfn_pkg::REM_W-3:0],
                        p_s[tfn_pkg::SUM_W-1-2*k], p_s[tfn_pkg::SUM_W-2-2*k]};
        assign n_try = {2'b00, p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_s[k]    <= p_s;
                r_side[k] <= p_side;
                if (n_sh >= n_try) begin
                    r_rem[k]  <= n_sh - n_try;
                    r_root[k] <= {p_root[tfn_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= n_sh;
                    r_root[k] <= {p_root[tfn_pkg::ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_root = r_root[STAGES-1];
    assign o_side = r_side[STAGES-1];
endmodule

@@ src/tfn_div.sv @@
// rounded quotient m * 2^14 / length, one quotient bit per stage, three lanes
module tfn_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [tfn_pkg::ROOT_W-1:0] i_len,
    input  tfn_pkg::t_side   i_side,
    output logic             o_vld,
    output logic [2:0][tfn_pkg::QUO_W-1:0] o_quo,
    output tfn_pkg::t_side   o_side
);
    localparam int STAGES = tfn_pkg::QUO_W;

    logic [2:0][tfn_pkg::NUM_W-1:0] r_num;
    logic [tfn_pkg::ROOT_W-1:0]     r_len0;
    tfn_pkg::t_side                 r_side0;
    logic                           r_vld0;

    logic [2:0][tfn_pkg::NUM_W-1:0] r_rem  [STAGES];
    logic [2:0][tfn_pkg::QUO_W-1:0] r_quo  [STAGES];
    logic [tfn_pkg::ROOT_W-1:0]     r_len  [STAGES];
    tfn_pkg::t_side                 r_side [STAGES];
    logic [STAGES-1:0]              r_vld;

    // numerator with half the divisor added for round to nearest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (i_en) begin
            r_vld0 <= i_vld;
        end
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= {1'b0, i_side.m[i], {tfn_pkg::FRAC_W{1'b0}}}
                          + {15'd0, i_len[tfn_pkg::ROOT_W-1:1]};
            end
            r_len0  <= i_len;
            r_side0 <= i_side;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam int SH = STAGES - 1 - k;
        logic [2:0][tfn_pkg::NUM_W-1:0] p_rem;
        logic [2:0][tfn_pkg::QUO_W-1:0] p_quo;
        logic [tfn_pkg::ROOT_W-1:0]     p_len;
        tfn_pkg::t_side                 p_side;
        logic                           p_vld;
        logic [tfn_pkg::NUM_W:0]        n_d;

        if (k == 0) begin : g_first
            assign p_rem  = r_num;
            assign p_quo  = '0;
            assign p_len  = r_len0;
            assign p_side = r_side0;
            assign p_vld  = r_vld0;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_quo  = r_quo[k-1];
            assign p_len  = r_len[k-1];
            assign p_side = r_side[k-1];
            assign p_vld  = r_vld[k-1];
        end

        assign n_d = {{(tfn_pkg::NUM_W+1-tfn_pkg::ROOT_W){1'b0}}, p_len} << SH;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
            if (i_en) begin
                r_len[k]  <= p_len;
                r_side[k] <= p_side;
                for (int i = 0; i < 3; i++) begin
                    if ({1'b0, p_rem[i]} >= n_d) begin
                        r_rem[k][i] <= tfn_pkg::NUM_W'({1'b0, p_rem[i]} - n_d);
                        r_quo[k][i] <= p_quo[i] | (tfn_pkg::QUO_W'(1) << SH);
                    end else begin
                        r_rem[k][i] <= p_rem[i];
                        r_quo[k][i] <= p_quo[i];
                    end
                end
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_quo  = r_quo[STAGES-1];
    assign o_side = r_side[STAGES-1];
endmodule

@@ src/triangle_face_normal.sv @@
// top level of the triangle unit face normal pipeline
// throughput: one word per cycle when the output does not stall
// the 32-stage square root and 16-stage divider set the depth
// the whole pipe advances together whenever the output register is empty or being taken
// reset (synchronous, active low) clears every stage valid bit and the output valid
// no state is kept between words
module triangle_face_normal (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tfn_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tfn_pkg::t_out  o_out_data
);
    // global advance: output slot free or emptying this cycle
    logic w_en;

    // cross product stage outputs
    logic            w_x_vld;
    tfn_pkg::t_cross w_x_data;

    // normalised magnitudes and sum of squares
    logic                       w_n_vld;
    logic [tfn_pkg::SUM_W-1:0]  w_n_sum;
    tfn_pkg::t_side             w_n_side;

    // vector length
    logic                       w_s_vld;
    logic [tfn_pkg::ROOT_W-1:0] w_s_root;
    tfn_pkg::t_side             w_s_side;

    // rounded component magnitudes
    logic                              w_d_vld;
    logic [2:0][tfn_pkg::QUO_W-1:0]    w_d_quo;
    tfn_pkg::t_side                    w_d_side;

    logic [2:0][tfn_pkg::OUT_W-1:0]    n_comp;
    tfn_pkg::t_out                     r_out;
    logic                              r_out_vld;

    assign w_en       = !r_out_vld || i_out_ready;
    assign o_in_ready = w_en;

    tfn_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in_valid),
        .i_data  (i_in_data),
        .o_vld   (w_x_vld),
        .o_data  (w_x_data)
    );

    tfn_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_x_vld),
        .i_data  (w_x_data),
        .o_vld   (w_n_vld),
        .o_sum   (w_n_sum),
        .o_side  (w_n_side)
    );

    tfn_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_n_vld),
        .i_sum   (w_n_sum),
        .i_side  (w_n_side),
        .o_vld   (w_s_vld),
        .o_root  (w_s_root),
        .o_side  (w_s_side)
    );

    tfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_s_vld),
        .i_len   (w_s_root),
        .i_side  (w_s_side),
        .o_vld   (w_d_vld),
        .o_quo   (w_d_quo),
        .o_side  (w_d_side)
    );

    // apply the cross product signs; a degenerate triangle gives a zero vector
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (w_d_side.degen) begin
                n_comp[i] = '0;
            end else if (w_d_side.neg[i]) begin
                n_comp[i] = ~{1'b0, w_d_quo[i]} + 1'b1;
            end else begin
                n_comp[i] = {1'b0, w_d_quo[i]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_d_vld;
        end
        if (w_en) begin
            r_out.normal_x   <= n_comp[0];
            r_out.normal_y   <= n_comp[1];
            r_out.normal_z   <= n_comp[2];
            r_out.degenerate <= w_d_side.degen;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
endmodule
